>>> rtl/smds_pkg.sv
// package for the shared memory double stack
// operation and status codes, default sizes; no dependencies
`timescale 1ns / 1ps

package smds_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int KIND_W         = 3;
    localparam int DATA_W         = 32;
    localparam int STATUS_W       = 2;
    localparam int CAP_W          = 11;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH1 = 3'd0,
        K_POP1  = 3'd1,
        K_PUSH2 = 3'd2,
        K_POP2  = 3'd3,
        K_PEEK1 = 3'd4,
        K_PEEK2 = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // register index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;

endpackage

>>> rtl/smds_req_if.sv
// request channel of the shared memory double stack
// depends on smds_pkg
`timescale 1ns / 1ps

interface smds_req_if;
    logic                              valid;
    logic                              ready;
    logic [smds_pkg::KIND_W-1:0]       kind;
    logic signed [smds_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output kind, output data_in, input ready);
    modport sink   (input valid, input kind, input data_in, output ready);
endinterface

>>> rtl/smds_rsp_if.sv
// response channel of the shared memory double stack
// depends on smds_pkg
`timescale 1ns / 1ps

interface smds_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [smds_pkg::STATUS_W-1:0]      status;
    logic signed [smds_pkg::DATA_W-1:0] data_out;
    logic                               first_empty;
    logic                               second_empty;
    logic                               both_full;

    modport source (output valid, output status, output data_out, output first_empty,
                    output second_empty, output both_full, input ready);
    modport sink   (input valid, input status, input data_out, input first_empty,
                    input second_empty, input both_full, output ready);
endinterface

>>> rtl/shared_memory_double_stack.sv
// two stacks in one synchronous memory, stack one upward, stack two downward
// depends on smds_pkg, smds_req_if, smds_rsp_if
// response: valid in the cycle after acceptance, none if a capacity write coincides
// throughput: one request per cycle while responses are taken, set by the single memory port
// reset: synchronous active low; both stacks empty, capacity = DEPTH,
// memory contents undefined until pushed, no clearing pass
`timescale 1ns / 1ps

module shared_memory_double_stack #(
    parameter int DEPTH      = smds_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = smds_pkg::WORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    smds_req_if.sink                          i_req,
    smds_rsp_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smds_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [smds_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [smds_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    logic [CNT_W-1:0] r_capacity, n_capacity;
    logic [CNT_W-1:0] r_first_count, n_first_count;
    logic [CNT_W-1:0] r_second_bottom, n_second_bottom;

    logic                          r_out_valid, n_out_valid;
    logic [smds_pkg::STATUS_W-1:0] r_status, n_status;
    logic                          r_rd_sel, n_rd_sel;
    logic                          r_first_empty, n_first_empty;
    logic                          r_second_empty, n_second_empty;
    logic                          r_both_full, n_both_full;
    logic [WORD_WIDTH-1:0]         r_rd_data;

    logic                  req_acc;
    logic                  cfg_wr;
    logic                  full;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [WORD_WIDTH-1:0] wr_word;
    logic [CNT_W-1:0]      cap_sat;
    smds_pkg::t_kind       kind;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_acc     = i_req.valid && i_req.ready;
    assign cfg_wr      = psel && penable && pwrite && (paddr[2] == smds_pkg::REG_CAPACITY);
    assign pready      = 1'b1;
    assign prdata      = smds_pkg::APB_DATA_W'(r_capacity);
    assign kind        = smds_pkg::t_kind'(i_req.kind);
    assign full        = r_first_count >= r_second_bottom;
    assign wr_word     = WORD_WIDTH'($unsigned(i_req.data_in));

    always_comb begin
        if (32'(pwdata[smds_pkg::CAP_W-1:0]) > 32'(DEPTH)) begin
            cap_sat = CNT_W'(DEPTH);
        end else begin
            cap_sat = CNT_W'(pwdata[smds_pkg::CAP_W-1:0]);
        end
    end

    always_comb begin
        n_capacity      = r_capacity;
        n_first_count   = r_first_count;
        n_second_bottom = r_second_bottom;
        n_out_valid     = r_out_valid && !o_rsp.ready;
        n_status        = r_status;
        n_rd_sel        = r_rd_sel;
        n_first_empty   = r_first_empty;
        n_second_empty  = r_second_empty;
        n_both_full     = r_both_full;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = AW'(r_first_count);

        if (cfg_wr) begin
            n_capacity      = cap_sat;
            n_first_count   = '0;
            n_second_bottom = cap_sat;
        end else if (req_acc) begin
            n_out_valid = 1'b1;
            n_status    = smds_pkg::ST_OK;
            n_rd_sel    = 1'b0;
            unique case (kind)
                smds_pkg::K_PUSH1: begin
                    if (full) begin
                        n_status = smds_pkg::ST_FULL;
                    end else begin
                        mem_we        = 1'b1;
                        mem_addr      = AW'(r_first_count);
                        n_first_count = r_first_count + 1'b1;
                    end
                end
                smds_pkg::K_PUSH2: begin
                    if (full) begin
                        n_status = smds_pkg::ST_FULL;
                    end else begin
                        mem_we          = 1'b1;
                        n_second_bottom = r_second_bottom - 1'b1;
                        mem_addr        = AW'(n_second_bottom);
                    end
                end
                smds_pkg::K_POP1, smds_pkg::K_PEEK1: begin
                    if (r_first_count == '0) begin
                        n_status = smds_pkg::ST_EMPTY;
                    end else begin
                        mem_re   = 1'b1;
                        n_rd_sel = 1'b1;
                        mem_addr = AW'(r_first_count - 1'b1);
                        if (kind == smds_pkg::K_POP1) begin
                            n_first_count = r_first_count - 1'b1;
                        end
                    end
                end
                smds_pkg::K_POP2, smds_pkg::K_PEEK2: begin
                    if (r_second_bottom >= r_capacity) begin
                        n_status = smds_pkg::ST_EMPTY;
                    end else begin
                        mem_re   = 1'b1;
                        n_rd_sel = 1'b1;
                        mem_addr = AW'(r_second_bottom);
                        if (kind == smds_pkg::K_POP2) begin
                            n_second_bottom = r_second_bottom + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            n_first_empty  = n_first_count == '0;
            n_second_empty = n_second_bottom >= r_capacity;
            n_both_full    = n_first_count >= n_second_bottom;
        end
    end

    // single port memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= wr_word;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity      <= CNT_W'(DEPTH);
            r_first_count   <= '0;
            r_second_bottom <= CNT_W'(DEPTH);
            r_out_valid     <= 1'b0;
        end else begin
            r_capacity      <= n_capacity;
            r_first_count   <= n_first_count;
            r_second_bottom <= n_second_bottom;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status       <= n_status;
        r_rd_sel       <= n_rd_sel;
        r_first_empty  <= n_first_empty;
        r_second_empty <= n_second_empty;
        r_both_full    <= n_both_full;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.data_out     = r_rd_sel ? smds_pkg::DATA_W'(r_rd_data) : '0;
    assign o_rsp.first_empty  = r_first_empty;
    assign o_rsp.second_empty = r_second_empty;
    assign o_rsp.both_full    = r_both_full;

endmodule
